>>> design/slws_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window latency statistics package
// Shared widths, opcodes, controller states and the cell command type.
// ----------------------------------------------------------------------------
package slws_pkg;

    localparam int DEPTH  = 256;
    localparam int IDX_W  = 8;
    localparam int CNT_W  = 9;
    localparam int DATA_W = 32;
    localparam int SUM_W  = 40;

    // Width of the divider's step counter, which counts down from SUM_W.
    localparam int DIV_STEP_W = $clog2(SUM_W + 1);

    // floor(x / 100) equals (x * PCT_RECIP) >> PCT_SHIFT for every x below 2^15.
    localparam int PCT_RECIP = 10486;
    localparam int PCT_SHIFT = 20;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REMOVE = 5'b00010,
        ST_INSERT = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_LOAD   = 5'b10000
    } state_t;

    typedef struct packed {
        logic remove;
        logic insert;
    } cell_cmd_t;

    // Sorted position of a percentile: floor(n * p / 100).
    function automatic logic [IDX_W-1:0] pct_index(input logic [CNT_W-1:0] n,
                                                   input logic [6:0] p);
        logic [15:0] x;
        logic [29:0] y;
        x = 16'(n) * 16'(p);
        y = 30'(x) * 30'(PCT_RECIP);
        return y[PCT_SHIFT+IDX_W-1:PCT_SHIFT];
    endfunction

endpackage

>>> design/slws_cell.sv
// ----------------------------------------------------------------------------
// Sorted cell
// One element of the sorted chain; shifts left on removal, right on insertion.
// ----------------------------------------------------------------------------
module slws_cell
    import slws_pkg::*;
(
    input  logic              clk,
    input  cell_cmd_t         cmd,
    input  logic [DATA_W-1:0] key,
    input  logic [DATA_W-1:0] left_val,
    input  logic              left_occ,
    input  logic [DATA_W-1:0] right_val,
    input  logic              occ,
    output logic [DATA_W-1:0] val
);

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        if (cmd.remove)
        begin
            // The chain is sorted, so every cell at or past the first copy of
            // the key holds a value not below it.
            if (occ && (val_reg >= key))
            begin
                val_next = right_val;
            end
        end
        else if (cmd.insert)
        begin
            if (occ || left_occ)
            begin
                if (left_val > key)
                begin
                    val_next = left_val;
                end
                else if (!occ || (val_reg > key))
                begin
                    val_next = key;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

>>> design/slws_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division of the window sum by the count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module slws_div
    import slws_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic              busy,
    output logic [DATA_W-1:0] quotient
);

    logic                  busy_reg;
    logic                  busy_next;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [DIV_STEP_W-1:0] step_next;
    logic [CNT_W-1:0]      rem_reg;
    logic [CNT_W-1:0]      rem_next;
    logic [SUM_W-1:0]      quot_reg;
    logic [SUM_W-1:0]      quot_next;
    logic [CNT_W-1:0]      div_reg;
    logic [CNT_W-1:0]      div_next;
    logic [CNT_W:0]        trial;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        div_next  = div_reg;
        trial     = {rem_reg, quot_reg[SUM_W-1]} - {1'b0, div_reg};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = DIV_STEP_W'(SUM_W);
            rem_next  = '0;
            quot_next = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[CNT_W])
            begin
                rem_next  = trial[CNT_W-1:0];
                quot_next = {quot_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = {rem_reg[CNT_W-2:0], quot_reg[SUM_W-1]};
                quot_next = {quot_reg[SUM_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == DIV_STEP_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        div_reg  <= div_next;
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg[DATA_W-1:0];

endmodule

>>> design/sliding_window_latency_stats.sv
// ----------------------------------------------------------------------------
// Sliding window latency statistics
// Keeps the latest samples and reports count, min, max, average, percentiles.
// ----------------------------------------------------------------------------
// Each request takes one item at a time. A record that fits passes the insert
// state; a record into a full window first passes the remove state, which takes
// the oldest sample out of the sorted cell chain. The divide state then starts
// the serial divider, and the load state waits for it to finish and loads the
// result register. A clear (or a record into an empty window of size zero)
// goes straight to the divide state. The load state also waits while the
// result register is still held by a stalled result, and no new request is
// taken until the load state is left. The result register lets the next
// request in while a result still waits to be taken.
module sliding_window_latency_stats
    import slws_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CNT_W-1:0]  window_size,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              opcode,
    input  logic [DATA_W-1:0] sample,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CNT_W-1:0]  count,
    output logic [DATA_W-1:0] min_latency,
    output logic [DATA_W-1:0] max_latency,
    output logic [DATA_W-1:0] avg_latency,
    output logic [DATA_W-1:0] median_latency,
    output logic [DATA_W-1:0] p95_latency,
    output logic [DATA_W-1:0] p99_latency
);

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  wsize_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [IDX_W-1:0]  ptr_reg;
    logic [IDX_W-1:0]  ptr_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] ring_rd_reg;
    logic [DATA_W-1:0] ring [DEPTH];
    logic              ring_we;
    logic [IDX_W-1:0]  ring_wa;
    logic [CNT_W-1:0]  limit;
    logic              accept;
    logic              out_free;
    logic              div_start;
    logic              div_busy;
    logic [DATA_W-1:0] div_quot;
    cell_cmd_t         cmd;
    logic [DATA_W-1:0] cell_key;
    logic [DATA_W-1:0] cell_val [DEPTH];
    logic              occ [DEPTH];
    logic [IDX_W-1:0]  idx_max;
    logic [IDX_W-1:0]  idx_p50;
    logic [IDX_W-1:0]  idx_p95_reg;
    logic [IDX_W-1:0]  idx_p99_reg;
    logic [DATA_W-1:0] max_stage_reg;
    logic [DATA_W-1:0] p50_stage_reg;
    logic [DATA_W-1:0] p95_stage_reg;
    logic [DATA_W-1:0] p99_stage_reg;
    logic              out_valid_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [DATA_W-1:0] min_reg;
    logic [DATA_W-1:0] max_reg;
    logic [DATA_W-1:0] avg_reg;
    logic [DATA_W-1:0] p50_reg;
    logic [DATA_W-1:0] p95_reg;
    logic [DATA_W-1:0] p99_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign limit     = (wsize_reg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : wsize_reg;
    assign idx_max   = cnt_reg[IDX_W-1:0] - 1'b1;
    assign idx_p50   = cnt_reg[CNT_W-1:1];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ptr_next   = ptr_reg;
        sum_next   = sum_reg;
        cmd        = '0;
        cell_key   = key_reg;
        ring_we    = 1'b0;
        ring_wa    = ptr_reg + cnt_reg[IDX_W-1:0];
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_CLEAR)
                    begin
                        cnt_next   = '0;
                        sum_next   = '0;
                        ptr_next   = '0;
                        state_next = ST_DIV;
                    end
                    else if ((10'(cnt_reg) + 10'd1) > 10'(limit))
                    begin
                        // A zero limit with an empty window records nothing.
                        state_next = (cnt_reg != '0) ? ST_REMOVE : ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_INSERT;
                    end
                end
            end
            ST_REMOVE:
            begin
                cmd.remove = 1'b1;
                cell_key   = ring_rd_reg;
                cnt_next   = cnt_reg - 1'b1;
                sum_next   = sum_reg - SUM_W'(ring_rd_reg);
                ptr_next   = ptr_reg + 1'b1;
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                cmd.insert = 1'b1;
                ring_we    = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                sum_next   = sum_reg + SUM_W'(key_reg);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                div_start  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!div_busy && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wsize_reg     <= CNT_W'(DEPTH);
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ptr_reg   <= ptr_next;
            sum_reg   <= sum_next;
            if (cfg_valid && cfg_ready)
            begin
                wsize_reg <= window_size;
            end
            if ((state_reg == ST_LOAD) && !div_busy && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Arrival ring; the oldest sample is read every cycle at the head pointer.
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring[ring_wa] <= key_reg;
        end
        ring_rd_reg <= ring[ptr_reg];
        if (accept)
        begin
            key_reg <= sample;
        end
        if (state_reg == ST_DIV)
        begin
            max_stage_reg <= cell_val[idx_max];
            p50_stage_reg <= cell_val[idx_p50];
            idx_p95_reg   <= pct_index(cnt_reg, 7'd95);
            idx_p99_reg   <= pct_index(cnt_reg, 7'd99);
        end
        // The chain holds still while the divider runs, so the upper
        // percentiles are picked up then, two cells a cycle.
        if (state_reg == ST_LOAD)
        begin
            p95_stage_reg <= cell_val[idx_p95_reg];
            p99_stage_reg <= cell_val[idx_p99_reg];
        end
        if ((state_reg == ST_LOAD) && !div_busy && out_free)
        begin
            count_reg <= cnt_reg;
            if (cnt_reg == '0)
            begin
                min_reg <= '0;
                max_reg <= '0;
                avg_reg <= '0;
                p50_reg <= '0;
                p95_reg <= '0;
                p99_reg <= '0;
            end
            else
            begin
                min_reg <= cell_val[0];
                max_reg <= max_stage_reg;
                avg_reg <= div_quot;
                p50_reg <= p50_stage_reg;
                p95_reg <= p95_stage_reg;
                p99_reg <= p99_stage_reg;
            end
        end
    end

    slws_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign occ[gi] = (CNT_W'(gi) < cnt_reg);
            if (gi == 0)
            begin : g_head
                slws_cell u_cell (
                    .clk       (clk),
                    .cmd       (cmd),
                    .key       (cell_key),
                    .left_val  ('0),
                    .left_occ  (1'b1),
                    .right_val (cell_val[gi+1]),
                    .occ       (occ[gi]),
                    .val       (cell_val[gi])
                );
            end
            else if (gi == DEPTH - 1)
            begin : g_tail
                slws_cell u_cell (
                    .clk       (clk),
                    .cmd       (cmd),
                    .key       (cell_key),
                    .left_val  (cell_val[gi-1]),
                    .left_occ  (occ[gi-1]),
                    .right_val (cell_val[gi]),
                    .occ       (occ[gi]),
                    .val       (cell_val[gi])
                );
            end
            else
            begin : g_mid
                slws_cell u_cell (
                    .clk       (clk),
                    .cmd       (cmd),
                    .key       (cell_key),
                    .left_val  (cell_val[gi-1]),
                    .left_occ  (occ[gi-1]),
                    .right_val (cell_val[gi+1]),
                    .occ       (occ[gi]),
                    .val       (cell_val[gi])
                );
            end
        end
    endgenerate

    assign out_valid      = out_valid_reg;
    assign count          = count_reg;
    assign min_latency    = min_reg;
    assign max_latency    = max_reg;
    assign avg_latency    = avg_reg;
    assign median_latency = p50_reg;
    assign p95_latency    = p95_reg;
    assign p99_latency    = p99_reg;

endmodule

>>> bench/sliding_window_latency_stats_checker.sv
// ----------------------------------------------------------------------------
// Sliding window latency statistics checker
// Watches the request, result and register channels, keeps its own window
// model, and compares every result field with the predicted statistics.
// ----------------------------------------------------------------------------
module sliding_window_latency_stats_checker
    import slws_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CNT_W-1:0]  window_size,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic              opcode,
    input  logic [DATA_W-1:0] sample,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [CNT_W-1:0]  count,
    input  logic [DATA_W-1:0] min_latency,
    input  logic [DATA_W-1:0] max_latency,
    input  logic [DATA_W-1:0] avg_latency,
    input  logic [DATA_W-1:0] median_latency,
    input  logic [DATA_W-1:0] p95_latency,
    input  logic [DATA_W-1:0] p99_latency,
    output int                errors,
    output int                pending
);

    localparam int PRED_DEPTH = 8;

    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] avg;
        logic [DATA_W-1:0] p50;
        logic [DATA_W-1:0] p95;
        logic [DATA_W-1:0] p99;
    } stats_t;

    stats_t            pred_mem[PRED_DEPTH];
    int                wr_count;
    int                rd_count;
    logic [DATA_W-1:0] arrivals[DEPTH];
    logic [DATA_W-1:0] ordered[DEPTH];
    int                head;
    int                held;
    logic [SUM_W-1:0]  total;
    int                limit_reg;

    assign pending = wr_count - rd_count;

    task automatic report(input string what, input logic [DATA_W-1:0] got,
                          input logic [DATA_W-1:0] want);
        $display("error: %s got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic logic [DATA_W-1:0] rank(input int pct);
        int k;
        k = (held * pct) / 100;
        if (k > held - 1)
            k = held - 1;
        return ordered[k];
    endfunction

    task automatic drop_oldest();
        logic [DATA_W-1:0] v;
        int i;
        v = arrivals[head];
        i = 0;
        while (i < held && ordered[i] != v)
            i++;
        for (; i + 1 < held; i++)
            ordered[i] = ordered[i + 1];
        held--;
        total -= v;
        head = (head + 1) % DEPTH;
    endtask

    task automatic append(input logic [DATA_W-1:0] v);
        int i;
        arrivals[(head + held) % DEPTH] = v;
        i = held;
        while (i > 0 && ordered[i - 1] > v)
        begin
            ordered[i] = ordered[i - 1];
            i--;
        end
        ordered[i] = v;
        held++;
        total += v;
    endtask

    task automatic predict_stats(input logic op, input logic [DATA_W-1:0] v);
        stats_t s;
        int lim;
        lim = (limit_reg > DEPTH) ? DEPTH : limit_reg;
        if (op == OP_CLEAR)
        begin
            held = 0;
            total = '0;
            head = 0;
        end
        else if (held + 1 > lim)
        begin
            if (held > 0)
            begin
                drop_oldest();
                append(v);
            end
        end
        else
            append(v);
        s = '0;
        if (held > 0)
        begin
            s.cnt = CNT_W'(held);
            s.lo  = ordered[0];
            s.hi  = ordered[held - 1];
            s.avg = DATA_W'(total / held);
            s.p50 = rank(50);
            s.p95 = rank(95);
            s.p99 = rank(99);
        end
        pred_mem[wr_count % PRED_DEPTH] = s;
        wr_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        stats_t e;
        if (!rst_n)
        begin
            errors    <= 0;
            head      = 0;
            held      = 0;
            total     = '0;
            limit_reg = DEPTH;
            wr_count  = 0;
            rd_count  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit_reg = window_size;
            if (out_valid && !out_stall)
            begin
                if (wr_count == rd_count)
                    report("result with no request", '0, '0);
                else
                begin
                    e = pred_mem[rd_count % PRED_DEPTH];
                    rd_count++;
                    if (count !== e.cnt)          report("count", count, e.cnt);
                    if (min_latency !== e.lo)     report("min", min_latency, e.lo);
                    if (max_latency !== e.hi)     report("max", max_latency, e.hi);
                    if (avg_latency !== e.avg)    report("avg", avg_latency, e.avg);
                    if (median_latency !== e.p50) report("p50", median_latency, e.p50);
                    if (p95_latency !== e.p95)    report("p95", p95_latency, e.p95);
                    if (p99_latency !== e.p99)    report("p99", p99_latency, e.p99);
                end
            end
            if (in_valid && !in_stall)
                predict_stats(opcode, sample);
        end
    end

endmodule

>>> bench/tb_sliding_window_latency_stats.sv
// ----------------------------------------------------------------------------
// Sliding window latency statistics testbench
// Drives directed and random record and clear requests under several window
// sizes with random idling on both sides; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_sliding_window_latency_stats
    import slws_pkg::*;
();

    localparam int WATCHDOG = 20000;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CNT_W-1:0]  window_size;
    logic              in_valid;
    logic              in_stall;
    logic              opcode;
    logic [DATA_W-1:0] sample;
    logic              out_valid;
    logic              out_stall;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] min_latency;
    logic [DATA_W-1:0] max_latency;
    logic [DATA_W-1:0] avg_latency;
    logic [DATA_W-1:0] median_latency;
    logic [DATA_W-1:0] p95_latency;
    logic [DATA_W-1:0] p99_latency;
    int                errors;
    int                pending;
    int                quiet_cycles;
    bit                calm;

    sliding_window_latency_stats i_dut (.*);

    sliding_window_latency_stats_checker i_checker (.*);

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Result-side stall comes in random bursts until the calm tail of the run.
    always @(posedge clk or negedge rst_n)
    begin
        int burst;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            burst = 0;
        end
        else if (calm)
            out_stall <= 1'b0;
        else if (burst > 0)
        begin
            burst--;
            if (burst == 0)
                out_stall <= 1'b0;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            burst = $urandom_range(1, 19);
            out_stall <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("sliding_window_latency_stats: mismatch");
            $finish;
        end
    end

    // Valid stays high from one request to the next unless an idle gap comes.
    task automatic send(input logic op, input logic [DATA_W-1:0] v);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        sample   <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drops valid and waits until every accepted request has its result.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_window(input logic [CNT_W-1:0] size);
        drain();
        repeat (60) @(posedge clk);
        cfg_valid   <= 1'b1;
        window_size <= size;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_run(input int n);
        for (int i = 0; i < n; i++)
            send(($urandom_range(0, 39) == 0) ? OP_CLEAR : OP_RECORD, rand_sample());
    endtask

    initial
    begin
        logic [CNT_W-1:0] sizes[5];
        quiet_cycles = 0;
        calm        = 1'b0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        window_size = '0;
        in_valid    = 1'b0;
        opcode      = OP_RECORD;
        sample      = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty window, extremes, equal samples, clear.
        send(OP_RECORD, '0);
        send(OP_CLEAR, 32'hFFFF_FFFF);
        send(OP_CLEAR, '0);
        send(OP_RECORD, 32'hFFFF_FFFF);
        send(OP_RECORD, 32'hFFFF_FFFF);
        send(OP_RECORD, 32'h5555_5555);
        send(OP_RECORD, 32'hAAAA_AAAA);
        send(OP_RECORD, 32'h0000_0001);
        send(OP_RECORD, 32'h0000_0001);
        send(OP_CLEAR, 32'h1234_5678);
        // Size zero keeps the window empty.
        set_window(9'd0);
        send(OP_RECORD, 32'd7);
        send(OP_RECORD, 32'd9);
        // Window of one replaces its only sample.
        set_window(9'd1);
        send(OP_RECORD, 32'd5);
        send(OP_RECORD, 32'd5);
        send(OP_RECORD, 32'd3);
        // Lower the size below the held count without clearing.
        set_window(9'd3);
        for (int i = 0; i < 3; i++)
            send(OP_RECORD, 32'(i + 10));
        set_window(9'd2);
        send(OP_RECORD, 32'd1);
        send(OP_RECORD, 32'd1);
        // Size above the depth acts as the full depth.
        set_window(9'd511);
        random_run(300);

        sizes = '{9'd256, 9'd4, 9'd17, 9'd100, 9'd1};
        foreach (sizes[k])
        begin
            set_window(sizes[k]);
            if (k == 4)
                calm = 1'b1;
            random_run(200);
        end

        drain();
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("sliding_window_latency_stats: match");
        else
            $display("sliding_window_latency_stats: mismatch");
        $finish;
    end

endmodule
